### src/sffw_pkg.sv
// Package for the simplex face form weights block: widths and constants.
// Used by every module of the block; depends on nothing else.
`default_nettype none
package sffw_pkg;

   localparam int SFFW_SPACE_DIMS = 3;
   localparam int FRAC_BITS       = 24;
   localparam int COORD_W         = 32;
   localparam int SUM_W           = 36;
   localparam int DIFF_W          = 33;
   localparam int SDIFF_W         = 37;
   localparam int PHI_W           = 40;
   localparam int OPND_W          = 48;
   localparam int HALF_W          = 24;
   localparam int PROD_W          = 64;
   localparam int ACC_W           = 66;
   localparam int WEIGHT_W        = 48;
   localparam int VERT_W          = 4;

   localparam logic [0:0] OP_LOAD  = 1'b0;
   localparam logic [0:0] OP_QUERY = 1'b1;

   localparam logic [1:0] CORNER_A = 2'd0;
   localparam logic [1:0] CORNER_B = 2'd1;
   localparam logic [1:0] CORNER_C = 2'd2;

   localparam logic [1:0] MPH_FIRST  = 2'd0;
   localparam logic [1:0] MPH_SECOND = 2'd1;
   localparam logic [1:0] MPH_TERM   = 2'd2;

endpackage
`default_nettype wire

### src/simplex_face_form_weights.sv
// Top level of the simplex face form weights block: corner store, sequencer.
// Instantiates sffw_div6 and sffw_qmul; uses sffw_pkg.
//
// A load transaction leaves busy low. A query transaction keeps busy high
// while, for each of its three terms, it performs one division by six,
// reads the vertex pair and forms three rounded products on the single
// shared 24 by 24 bit multiplier, then doubles and saturates the sum. A
// vertex beyond the space skips the division, and an equal or out-of-range
// pair skips the two determinant products. The weight then appears on
// rsp_face_weight with rsp_strobe high for one cycle; the receiver cannot
// stall it, so it must take it in that cycle.
`default_nettype none
module simplex_face_form_weights
   import sffw_pkg::*;
#(
   parameter int SPACE_DIMS = SFFW_SPACE_DIMS
) (
   input  wire                       clock,
   input  wire                       reset,
   input  wire                       start,
   output logic                      busy,
   input  wire  [0:0]                req_opcode,
   input  wire  [1:0]                req_corner_select,
   input  wire  [2:0]                req_coord_index,
   input  wire  signed [COORD_W-1:0] req_coord_value,
   input  wire  [VERT_W-1:0]         req_face_first,
   input  wire  [VERT_W-1:0]         req_face_second,
   input  wire  [VERT_W-1:0]         req_face_third,
   output logic                      rsp_strobe,
   output logic signed [WEIGHT_W-1:0] rsp_face_weight
);

   localparam int IDX_W = (SPACE_DIMS > 1) ? $clog2(SPACE_DIMS) : 1;
   localparam logic [VERT_W-1:0] DIMS_V = VERT_W'(SPACE_DIMS);
   localparam logic signed [ACC_W-1:0] W_MAX =
      ACC_W'({1'b0, {(WEIGHT_W-1){1'b1}}});
   localparam logic signed [ACC_W-1:0] W_MIN = -W_MAX - ACC_W'(1);

   typedef enum logic [2:0] {
      S_IDLE, S_PHI, S_PHI_WAIT, S_DET_HI, S_DET_LO, S_MUL, S_MUL_WAIT, S_FINISH
   } state_type;

   logic signed [COORD_W-1:0] coord_a_ff [SPACE_DIMS];
   logic signed [COORD_W-1:0] coord_b_ff [SPACE_DIMS];
   logic signed [COORD_W-1:0] coord_c_ff [SPACE_DIMS];
   logic signed [SUM_W-1:0]   sum_a_ff, sum_b_ff, sum_c_ff;

   state_type                 state_ff, state_in;
   logic [1:0]                term_ff, term_in;
   logic [1:0]                mphase_ff, mphase_in;
   logic [VERT_W-1:0]         vert_ff [3];
   logic                      sign_ff, sign_in;
   logic signed [PHI_W-1:0]   phi_ff, phi_in;
   logic signed [DIFF_W-1:0]  dbq_ff, dbq_in, dcq_ff, dcq_in;
   logic signed [SDIFF_W-1:0] x1_ff, x1_in, x2_ff, x2_in;
   logic signed [PROD_W-1:0]  prod1_ff, prod1_in;
   logic signed [OPND_W-1:0]  det_ff, det_in;
   logic signed [ACC_W-1:0]   acc_ff, acc_in;
   logic                      strobe_ff, strobe_in;
   logic signed [WEIGHT_W-1:0] weight_ff, weight_in;

   logic [VERT_W-1:0]         v_cur, p_cur, q_cur, lo_v, hi_v, idx_v;
   logic                      pair_zero;
   logic [IDX_W-1:0]          rd_idx;
   logic signed [COORD_W-1:0] a_rd, b_rd, c_rd;
   logic signed [DIFF_W-1:0]  db_rd, dc_rd;
   logic signed [SDIFF_W-1:0] s0, s1, s2;
   logic signed [PHI_W-1:0]   phi_num;
   logic                      div_start, div_done, mul_start, mul_done;
   logic signed [PHI_W-1:0]   div_quot;
   logic signed [OPND_W-1:0]  mul_a, mul_b;
   logic signed [PROD_W-1:0]  mul_prod, det_diff;
   logic signed [ACC_W-1:0]   w_dbl;
   logic                      load_ok;
   logic signed [COORD_W-1:0] old_val;
   logic signed [DIFF_W-1:0]  delta;

   always_comb begin
      case (term_ff)
         2'd0: begin
            v_cur = vert_ff[0]; p_cur = vert_ff[1]; q_cur = vert_ff[2];
         end
         2'd1: begin
            v_cur = vert_ff[1]; p_cur = vert_ff[2]; q_cur = vert_ff[0];
         end
         default: begin
            v_cur = vert_ff[2]; p_cur = vert_ff[0]; q_cur = vert_ff[1];
         end
      endcase
      lo_v      = (p_cur < q_cur) ? p_cur : q_cur;
      hi_v      = (p_cur < q_cur) ? q_cur : p_cur;
      pair_zero = (p_cur == q_cur) || (p_cur > DIMS_V) || (q_cur > DIMS_V);
      case (state_ff)
         S_PHI:    idx_v = v_cur - VERT_W'(1);
         S_DET_HI: idx_v = hi_v - VERT_W'(1);
         S_DET_LO: idx_v = lo_v - VERT_W'(1);
         default:  idx_v = VERT_W'(req_coord_index);
      endcase
      rd_idx = idx_v[IDX_W-1:0];
      a_rd   = coord_a_ff[rd_idx];
      b_rd   = coord_b_ff[rd_idx];
      c_rd   = coord_c_ff[rd_idx];
      db_rd  = DIFF_W'(b_rd) - DIFF_W'(a_rd);
      dc_rd  = DIFF_W'(c_rd) - DIFF_W'(a_rd);
      s0     = (SDIFF_W'(1) <<< FRAC_BITS) - SDIFF_W'(sum_a_ff);
      s1     = SDIFF_W'(sum_a_ff) - SDIFF_W'(sum_b_ff);
      s2     = SDIFF_W'(sum_a_ff) - SDIFF_W'(sum_c_ff);
      if (v_cur == VERT_W'(0)) begin
         phi_num = PHI_W'(3) * PHI_W'(s0) + PHI_W'(s1) + PHI_W'(s2);
      end else begin
         phi_num = PHI_W'(3) * PHI_W'(a_rd) + PHI_W'(db_rd) + PHI_W'(dc_rd);
      end
      case (mphase_ff)
         MPH_FIRST: begin
            mul_a = OPND_W'(x1_ff); mul_b = OPND_W'(dcq_ff);
         end
         MPH_SECOND: begin
            mul_a = OPND_W'(x2_ff); mul_b = OPND_W'(dbq_ff);
         end
         default: begin
            mul_a = OPND_W'(phi_ff); mul_b = det_ff;
         end
      endcase
      det_diff = prod1_ff - mul_prod;
      w_dbl    = acc_ff <<< 1;
   end

   sffw_div6 u_div6 (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (phi_num),
      .done  (div_done),
      .quot  (div_quot)
   );

   sffw_qmul u_qmul (
      .clock   (clock),
      .reset   (reset),
      .start   (mul_start),
      .a_in    (mul_a),
      .b_in    (mul_b),
      .done    (mul_done),
      .product (mul_prod)
   );

   always_comb begin
      load_ok = (state_ff == S_IDLE) && start && (req_opcode == OP_LOAD) &&
                (req_corner_select <= CORNER_C) &&
                ({1'b0, req_coord_index} < VERT_W'(SPACE_DIMS));
      case (req_corner_select)
         CORNER_A: old_val = a_rd;
         CORNER_B: old_val = b_rd;
         default:  old_val = c_rd;
      endcase
      delta = DIFF_W'(req_coord_value) - DIFF_W'(old_val);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int n = 0; n < SPACE_DIMS; n++) begin
            coord_a_ff[n] <= '0;
            coord_b_ff[n] <= '0;
            coord_c_ff[n] <= '0;
         end
         sum_a_ff <= '0;
         sum_b_ff <= '0;
         sum_c_ff <= '0;
      end else if (load_ok) begin
         case (req_corner_select)
            CORNER_A: begin
               coord_a_ff[rd_idx] <= req_coord_value;
               sum_a_ff <= sum_a_ff + SUM_W'(delta);
            end
            CORNER_B: begin
               coord_b_ff[rd_idx] <= req_coord_value;
               sum_b_ff <= sum_b_ff + SUM_W'(delta);
            end
            default: begin
               coord_c_ff[rd_idx] <= req_coord_value;
               sum_c_ff <= sum_c_ff + SUM_W'(delta);
            end
         endcase
      end
   end

   always_comb begin
      state_in  = state_ff;
      term_in   = term_ff;
      mphase_in = mphase_ff;
      sign_in   = sign_ff;
      phi_in    = phi_ff;
      dbq_in    = dbq_ff;
      dcq_in    = dcq_ff;
      x1_in     = x1_ff;
      x2_in     = x2_ff;
      prod1_in  = prod1_ff;
      det_in    = det_ff;
      acc_in    = acc_ff;
      strobe_in = 1'b0;
      weight_in = weight_ff;
      div_start = 1'b0;
      mul_start = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (start && (req_opcode == OP_QUERY)) begin
               term_in  = 2'd0;
               acc_in   = '0;
               state_in = S_PHI;
            end
         end
         S_PHI: begin
            if (v_cur > DIMS_V) begin
               phi_in   = '0;
               state_in = S_DET_HI;
            end else begin
               div_start = 1'b1;
               state_in  = S_PHI_WAIT;
            end
         end
         S_PHI_WAIT: begin
            if (div_done) begin
               phi_in   = div_quot;
               state_in = S_DET_HI;
            end
         end
         S_DET_HI: begin
            dbq_in  = db_rd;
            dcq_in  = dc_rd;
            sign_in = p_cur > q_cur;
            if (pair_zero) begin
               det_in    = '0;
               mphase_in = MPH_TERM;
               state_in  = S_MUL;
            end else begin
               state_in = S_DET_LO;
            end
         end
         S_DET_LO: begin
            if (lo_v == VERT_W'(0)) begin
               x1_in = s1;
               x2_in = s2;
            end else begin
               x1_in = SDIFF_W'(db_rd);
               x2_in = SDIFF_W'(dc_rd);
            end
            mphase_in = MPH_FIRST;
            state_in  = S_MUL;
         end
         S_MUL: begin
            mul_start = 1'b1;
            state_in  = S_MUL_WAIT;
         end
         S_MUL_WAIT: begin
            if (mul_done) begin
               case (mphase_ff)
                  MPH_FIRST: begin
                     prod1_in  = mul_prod;
                     mphase_in = MPH_SECOND;
                     state_in  = S_MUL;
                  end
                  MPH_SECOND: begin
                     det_in    = sign_ff ? OPND_W'(-det_diff) : OPND_W'(det_diff);
                     mphase_in = MPH_TERM;
                     state_in  = S_MUL;
                  end
                  default: begin
                     acc_in = acc_ff + ACC_W'(mul_prod);
                     if (term_ff == 2'd2) begin
                        state_in = S_FINISH;
                     end else begin
                        term_in  = term_ff + 2'd1;
                        state_in = S_PHI;
                     end
                  end
               endcase
            end
         end
         S_FINISH: begin
            if (w_dbl > W_MAX) begin
               weight_in = WEIGHT_W'(W_MAX);
            end else if (w_dbl < W_MIN) begin
               weight_in = WEIGHT_W'(W_MIN);
            end else begin
               weight_in = WEIGHT_W'(w_dbl);
            end
            strobe_in = 1'b1;
            state_in  = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         term_ff   <= 2'd0;
         mphase_ff <= MPH_FIRST;
         strobe_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         term_ff   <= term_in;
         mphase_ff <= mphase_in;
         strobe_ff <= strobe_in;
      end
      if ((state_ff == S_IDLE) && start && (req_opcode == OP_QUERY)) begin
         vert_ff[0] <= req_face_first;
         vert_ff[1] <= req_face_second;
         vert_ff[2] <= req_face_third;
      end
      sign_ff   <= sign_in;
      phi_ff    <= phi_in;
      dbq_ff    <= dbq_in;
      dcq_ff    <= dcq_in;
      x1_ff     <= x1_in;
      x2_ff     <= x2_in;
      prod1_ff  <= prod1_in;
      det_ff    <= det_in;
      acc_ff    <= acc_in;
      weight_ff <= weight_in;
   end

   assign busy            = (state_ff != S_IDLE);
   assign rsp_strobe      = strobe_ff;
   assign rsp_face_weight = weight_ff;

endmodule
`default_nettype wire

### src/sffw_qmul.sv
// Shared fixed-point multiplier: rounded Q.24 product of two signed operands.
// Built on one 24 by 24 bit multiplier that forms the partial products in turn; uses sffw_pkg.
`default_nettype none
module sffw_qmul
   import sffw_pkg::*;
(
   input  wire                     clock,
   input  wire                     reset,
   input  wire                     start,
   input  wire signed [OPND_W-1:0] a_in,
   input  wire signed [OPND_W-1:0] b_in,
   output logic                    done,
   output logic signed [PROD_W-1:0] product
);

   logic [OPND_W-1:0]   mag_a_ff, mag_a_in;
   logic [OPND_W-1:0]   mag_b_ff, mag_b_in;
   logic                neg_ff, neg_in;
   logic [PROD_W-1:0]   acc_ff, acc_in;
   logic [1:0]          step_ff, step_in;
   logic                active_ff, active_in;
   logic                done_ff, done_in;
   logic [HALF_W-1:0]   half_a, half_b;
   logic [2*HALF_W-1:0] part;

   always_comb begin
      half_a = step_ff[0] ? mag_a_ff[OPND_W-1:HALF_W] : mag_a_ff[HALF_W-1:0];
      half_b = step_ff[1] ? mag_b_ff[OPND_W-1:HALF_W] : mag_b_ff[HALF_W-1:0];
      part   = half_a * half_b;
   end

   always_comb begin
      mag_a_in  = mag_a_ff;
      mag_b_in  = mag_b_ff;
      neg_in    = neg_ff;
      acc_in    = acc_ff;
      step_in   = step_ff;
      active_in = active_ff;
      done_in   = 1'b0;
      if (start) begin
         mag_a_in  = a_in[OPND_W-1] ? OPND_W'(-a_in) : OPND_W'(a_in);
         mag_b_in  = b_in[OPND_W-1] ? OPND_W'(-b_in) : OPND_W'(b_in);
         neg_in    = a_in[OPND_W-1] ^ b_in[OPND_W-1];
         step_in   = 2'd0;
         active_in = 1'b1;
      end else if (active_ff) begin
         case (step_ff)
            2'd0: begin
               acc_in = (PROD_W'(part) + (PROD_W'(1) << (FRAC_BITS - 1))) >> FRAC_BITS;
            end
            2'd3: begin
               acc_in    = acc_ff + (PROD_W'(part) << FRAC_BITS);
               active_in = 1'b0;
               done_in   = 1'b1;
            end
            default: begin
               acc_in = acc_ff + PROD_W'(part);
            end
         endcase
         step_in = step_ff + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      mag_a_ff <= mag_a_in;
      mag_b_ff <= mag_b_in;
      neg_ff   <= neg_in;
      acc_ff   <= acc_in;
      step_ff  <= step_in;
      if (reset) begin
         active_ff <= 1'b0;
         done_ff   <= 1'b0;
      end else begin
         active_ff <= active_in;
         done_ff   <= done_in;
      end
   end

   assign done    = done_ff;
   assign product = neg_ff ? -$signed(acc_ff) : $signed(acc_ff);

endmodule
`default_nettype wire

### src/sffw_div6.sv
// Divider by six with rounding to nearest, ties away from zero.
// Halves the rounded magnitude, then divides by three by reciprocal
// multiplication in the next cycle; uses sffw_pkg.
`default_nettype none
module sffw_div6
   import sffw_pkg::*;
(
   input  wire                    clock,
   input  wire                    reset,
   input  wire                    start,
   input  wire signed [PHI_W-1:0] num,
   output logic                   done,
   output logic signed [PHI_W-1:0] quot
);

   localparam int LO_W        = 20;
   localparam int Y_W         = LO_W + 1;
   localparam int YS_W        = 2 * Y_W;
   localparam int RECIP_SHIFT = 22;
   localparam logic [LO_W-1:0] THIRD_HI = LO_W'(349525);
   localparam logic [Y_W-1:0]  RECIP    = Y_W'(1398102);

   logic [PHI_W-1:0] x_ff, x_in;
   logic [PHI_W-1:0] q_ff, q_in;
   logic             neg_ff, neg_in;
   logic             active_ff, active_in;
   logic             done_ff, done_in;
   logic [PHI_W-1:0] mag;
   logic [Y_W-1:0]   y;
   logic [YS_W-1:0]  y_scaled;
   logic [PHI_W-1:0] q_hi;

   // Since 2^20 leaves a remainder of one when divided by three, the high
   // half contributes a fixed multiple and the folded sum of both halves is
   // divided by three through a reciprocal.
   always_comb begin
      mag       = num[PHI_W-1] ? PHI_W'(-num) : PHI_W'(num);
      y         = Y_W'(x_ff[PHI_W-1:LO_W]) + Y_W'(x_ff[LO_W-1:0]);
      y_scaled  = YS_W'(y) * YS_W'(RECIP);
      q_hi      = PHI_W'(x_ff[PHI_W-1:LO_W]) * PHI_W'(THIRD_HI);
      x_in      = x_ff;
      q_in      = q_ff;
      neg_in    = neg_ff;
      active_in = active_ff;
      done_in   = 1'b0;
      if (start) begin
         x_in      = (mag + PHI_W'(3)) >> 1;
         neg_in    = num[PHI_W-1];
         active_in = 1'b1;
      end else if (active_ff) begin
         q_in      = q_hi + PHI_W'(y_scaled >> RECIP_SHIFT);
         active_in = 1'b0;
         done_in   = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      x_ff   <= x_in;
      q_ff   <= q_in;
      neg_ff <= neg_in;
      if (reset) begin
         active_ff <= 1'b0;
         done_ff   <= 1'b0;
      end else begin
         active_ff <= active_in;
         done_ff   <= done_in;
      end
   end

   assign done = done_ff;
   assign quot = neg_ff ? -$signed(q_ff) : $signed(q_ff);

endmodule
`default_nettype wire
